[sv/hashed_feature_accumulator_defines.svh]
// Assertion macros for the hashed feature accumulator checker.
// No dependencies; the including scope must declare clk and arst_n.
`ifndef HASHED_FEATURE_ACCUMULATOR_DEFINES_SVH
`define HASHED_FEATURE_ACCUMULATOR_DEFINES_SVH

// same-cycle implication
`define HFA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HFA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/hfa_pkg.sv]
// Shared constants, codes and types of the hashed feature accumulator.
// No dependencies.
package hfa_pkg;

	localparam int NUM_COEFFS = 8;
	localparam int LANE_W     = (NUM_COEFFS > 1) ? $clog2(NUM_COEFFS) : 1;

	localparam logic [63:0] GOLDEN = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] MIXK1  = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIXK2  = 64'h94d049bb133111eb;

	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_ENTRY = 2'd1;
	localparam logic [1:0] CMD_PARAM = 2'd2;
	localparam logic [1:0] CMD_READ  = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NONFINITE = 2'd1;
	localparam logic [1:0] ST_NO_ENTRY  = 2'd2;

	typedef struct packed {
		logic clr;
		logic push;
		logic apply;
		logic rotate;
	} cell_ctrl_t;

	// elaboration only: mix of a small lane number
	function automatic logic [63:0] hmix_const(input logic [63:0] x);
		logic [63:0] v;
		v = x + GOLDEN;
		v = (v ^ (v >> 30)) * MIXK1;
		v = (v ^ (v >> 27)) * MIXK2;
		return v ^ (v >> 31);
	endfunction

	// per-lane combine key: mix(k) + golden
	function automatic logic [NUM_COEFFS*64-1:0] lane_keys();
		logic [NUM_COEFFS*64-1:0] keys;
		keys = '0;
		for (int k = 0; k < NUM_COEFFS; k++) begin
			keys[k*64 +: 64] = hmix_const(64'(k)) + GOLDEN;
		end
		return keys;
	endfunction

	localparam logic [NUM_COEFFS*64-1:0] LANE_KEYS = lane_keys();

endpackage

[sv/hfa_mix.sv]
// Iterative 64-bit mixer: add, two xor-shift/multiply rounds, final xor-shift.
// Each 64x64 low product takes three passes of one 32x32 multiplier.
// Depends on hfa_pkg.
module hfa_mix (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] din,
	output logic        done,
	output logic [63:0] dout
);

	localparam logic [2:0] M_IDLE = 3'd0;
	localparam logic [2:0] M_MUL1 = 3'd1;
	localparam logic [2:0] M_XOR  = 3'd2;
	localparam logic [2:0] M_MUL2 = 3'd3;
	localparam logic [2:0] M_FIN  = 3'd4;

	localparam logic [1:0] PH_LL = 2'd0;
	localparam logic [1:0] PH_LH = 2'd1;
	localparam logic [1:0] PH_HL = 2'd2;

	logic [2:0]  st_q;
	logic [1:0]  ph_q;
	logic [63:0] op_q;
	logic [63:0] prod_q;
	logic [63:0] seed_add;
	logic [63:0] kmul;
	logic [31:0] a_op;
	logic [31:0] b_op;
	logic [63:0] mprod;

	assign seed_add = din + hfa_pkg::GOLDEN;
	assign kmul     = (st_q == M_MUL1) ? hfa_pkg::MIXK1 : hfa_pkg::MIXK2;
	assign a_op     = (ph_q == PH_HL) ? op_q[63:32] : op_q[31:0];
	assign b_op     = (ph_q == PH_LH) ? kmul[63:32] : kmul[31:0];
	assign mprod    = a_op * b_op;

	assign done = (st_q == M_FIN);
	assign dout = prod_q ^ (prod_q >> 31);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= M_IDLE;
			ph_q <= PH_LL;
		end else begin
			case (st_q)
				M_IDLE: begin
					ph_q <= PH_LL;
					if (start) begin
						st_q <= M_MUL1;
					end
				end
				M_MUL1, M_MUL2: begin
					if (ph_q == PH_HL) begin
						ph_q <= PH_LL;
						st_q <= (st_q == M_MUL1) ? M_XOR : M_FIN;
					end else begin
						ph_q <= ph_q + 2'd1;
					end
				end
				M_XOR:   st_q <= M_MUL2;
				M_FIN:   st_q <= M_IDLE;
				default: st_q <= M_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == M_IDLE && start) begin
			op_q <= seed_add ^ (seed_add >> 30);
		end else if (st_q == M_XOR) begin
			op_q <= prod_q ^ (prod_q >> 27);
		end
		if (st_q inside {M_MUL1, M_MUL2}) begin
			if (ph_q == PH_LL) begin
				prod_q <= mprod;
			end else begin
				prod_q <= prod_q + {mprod[31:0], 32'd0};
			end
		end
	end

endmodule

[sv/hfa_cell.sv]
// One coefficient cell: saturating sum and a unit stage, linked to its neighbors.
// Depends on hfa_pkg.
module hfa_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  hfa_pkg::cell_ctrl_t ctrl,
	input  logic [63:0]         unit_in,
	input  logic [63:0]         sum_in,
	output logic [63:0]         unit_out,
	output logic [63:0]         sum_out
);

	logic [63:0] sum_q;
	logic [63:0] unit_q;
	logic [64:0] wide;
	logic [63:0] sat;

	assign wide = {sum_q[63], sum_q} + {unit_q[63], unit_q};

	always_comb begin
		if (wide[64] != wide[63]) begin
			sat = wide[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		end else begin
			sat = wide[63:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctrl.clr) begin
			sum_q <= '0;
		end else if (ctrl.apply) begin
			sum_q <= sat;
		end else if (ctrl.rotate) begin
			sum_q <= sum_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			unit_q <= unit_in;
		end
	end

	assign unit_out = unit_q;
	assign sum_out  = sum_q;

endmodule

[sv/hashed_feature_accumulator.sv]
// Hashed feature accumulator: folds genome entries and their parameters into
// hfa_pkg::NUM_COEFFS saturating fixed-point sums (52 fraction bits). One item is
// worked on at a time; a result waiting in the output register does not block
// the next item. All hashing runs on one mixer whose 32x32 multiplier does each
// 64-bit product in three passes.
module hashed_feature_accumulator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [31:0] entry_pos,
	input  logic [63:0] type_id,
	input  logic [63:0] param_id,
	input  logic [63:0] value_bits,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  coef_index,
	output logic [63:0] coef_value,
	output logic [1:0]  status,
	output logic        last
);

	localparam int NC = hfa_pkg::NUM_COEFFS;
	localparam int LW = hfa_pkg::LANE_W;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_VSTART = 4'd1;
	localparam logic [3:0] S_VWAIT  = 4'd2;
	localparam logic [3:0] S_PRE1   = 4'd3;
	localparam logic [3:0] S_PRE2   = 4'd4;
	localparam logic [3:0] S_XWAIT  = 4'd5;
	localparam logic [3:0] S_APPLY  = 4'd6;
	localparam logic [3:0] S_RESP   = 4'd7;
	localparam logic [3:0] S_READ   = 4'd8;

	logic [3:0]    st_q;
	logic          entry_open_q;
	logic [63:0]   entry_seed_q;
	logic          is_entry_q;
	logic          second_q;
	logic          lane_mode_q;
	logic [LW-1:0] lane_q;
	logic [LW-1:0] lane_nxt;
	logic [LW-1:0] rd_q;
	logic [63:0]   s_q;
	logic [63:0]   v_q;
	logic [63:0]   v2_q;
	logic [63:0]   key_q;
	logic [63:0]   acc_q;
	logic [1:0]    rstat_q;

	logic          out_valid_q;
	logic [2:0]    coef_index_q;
	logic [63:0]   coef_value_q;
	logic [1:0]    status_q;
	logic          last_q;

	logic          accept;
	logic          out_free;
	logic          load_resp;
	logic          load_read;
	logic          rd_last;
	logic          mix_start;
	logic          mix_done;
	logic [63:0]   mix_din;
	logic [63:0]   mix_dout;
	logic [63:0]   pre_x;
	logic [63:0]   unit_new;
	logic          nonfinite;

	hfa_pkg::cell_ctrl_t ctrl;
	logic [63:0]         unit_o [NC];
	logic [63:0]         sum_o  [NC];

	assign in_ready  = (st_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign load_resp = (st_q == S_RESP) && out_free;
	assign load_read = (st_q == S_READ) && out_free;
	assign rd_last   = (rd_q == LW'(NC - 1));
	assign lane_nxt  = lane_q - 1'b1;
	assign nonfinite = &value_bits[62:52];

	assign pre_x     = s_q ^ (acc_q + (s_q >> 2));
	assign mix_start = (st_q == S_VSTART) || (st_q == S_PRE2);
	assign mix_din   = (st_q == S_VSTART) ? v_q : pre_x;
	// (h >> 11) - 2^52
	assign unit_new  = {{12{~mix_dout[63]}}, mix_dout[62:11]};

	assign ctrl.clr    = accept && (cmd == hfa_pkg::CMD_CLEAR);
	assign ctrl.push   = (st_q == S_XWAIT) && mix_done && lane_mode_q;
	assign ctrl.apply  = (st_q == S_APPLY);
	assign ctrl.rotate = load_read;

	hfa_mix u_mix (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mix_start),
		.din    (mix_din),
		.done   (mix_done),
		.dout   (mix_dout)
	);

	for (genvar i = 0; i < NC; i++) begin : g_cell
		localparam int NXT = (i + 1) % NC;
		logic [63:0] uin;
		if (i == 0) begin : g_head
			assign uin = unit_new;
		end else begin : g_body
			assign uin = unit_o[i-1];
		end
		hfa_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.unit_in  (uin),
			.sum_in   (sum_o[NXT]),
			.unit_out (unit_o[i]),
			.sum_out  (sum_o[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= S_IDLE;
			entry_open_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (load_resp || load_read) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (accept) begin
						case (cmd)
							hfa_pkg::CMD_CLEAR: st_q <= S_RESP;
							hfa_pkg::CMD_ENTRY: st_q <= S_VSTART;
							hfa_pkg::CMD_PARAM: begin
								st_q <= (entry_open_q && !nonfinite) ? S_VSTART : S_RESP;
							end
							default: st_q <= S_READ;
						endcase
					end
				end
				S_VSTART: st_q <= S_VWAIT;
				S_VWAIT: begin
					if (mix_done) begin
						st_q <= S_PRE1;
					end
				end
				S_PRE1: st_q <= S_PRE2;
				S_PRE2: st_q <= S_XWAIT;
				S_XWAIT: begin
					if (mix_done) begin
						if (!lane_mode_q) begin
							if (is_entry_q) begin
								entry_open_q <= 1'b1;
							end
							st_q <= second_q ? S_VSTART : S_PRE1;
						end else begin
							st_q <= (lane_q == '0) ? S_APPLY : S_PRE1;
						end
					end
				end
				S_APPLY: st_q <= S_RESP;
				S_RESP: begin
					if (out_free) begin
						st_q <= S_IDLE;
					end
				end
				S_READ: begin
					if (out_free && rd_last) begin
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			is_entry_q  <= (cmd == hfa_pkg::CMD_ENTRY);
			second_q    <= (cmd == hfa_pkg::CMD_PARAM);
			lane_mode_q <= 1'b0;
			rd_q        <= '0;
			v_q         <= (cmd == hfa_pkg::CMD_ENTRY) ? type_id : param_id;
			v2_q        <= (value_bits == {1'b1, 63'd0}) ? 64'd0 : value_bits;
			s_q         <= (cmd == hfa_pkg::CMD_ENTRY) ? {32'd0, entry_pos} : entry_seed_q;
			if (cmd == hfa_pkg::CMD_PARAM && !entry_open_q) begin
				rstat_q <= hfa_pkg::ST_NO_ENTRY;
			end else if (cmd == hfa_pkg::CMD_PARAM && nonfinite) begin
				rstat_q <= hfa_pkg::ST_NONFINITE;
			end else begin
				rstat_q <= hfa_pkg::ST_OK;
			end
		end
		if (st_q == S_VWAIT && mix_done) begin
			key_q <= mix_dout + hfa_pkg::GOLDEN;
		end
		if (st_q == S_PRE1) begin
			acc_q <= key_q + (s_q << 6);
		end
		if (st_q == S_XWAIT && mix_done) begin
			if (!lane_mode_q) begin
				s_q <= mix_dout;
				if (is_entry_q) begin
					entry_seed_q <= mix_dout;
				end
				if (second_q) begin
					second_q <= 1'b0;
					v_q      <= v2_q;
				end else begin
					lane_mode_q <= 1'b1;
					lane_q      <= LW'(NC - 1);
					key_q       <= hfa_pkg::LANE_KEYS[(NC-1)*64 +: 64];
				end
			end else begin
				lane_q <= lane_nxt;
				key_q  <= hfa_pkg::LANE_KEYS[lane_nxt*64 +: 64];
			end
		end
		if (load_read) begin
			rd_q <= rd_q + 1'b1;
		end
		if (load_resp) begin
			coef_index_q <= 3'd0;
			coef_value_q <= 64'd0;
			status_q     <= rstat_q;
			last_q       <= 1'b1;
		end else if (load_read) begin
			coef_index_q <= 3'(rd_q);
			coef_value_q <= sum_o[0];
			status_q     <= hfa_pkg::ST_OK;
			last_q       <= rd_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign coef_index = coef_index_q;
	assign coef_value = coef_value_q;
	assign status     = status_q;
	assign last       = last_q;

endmodule

[sv/hfa_checker.sv]
// Port-level checker for hashed_feature_accumulator, attached by bind.
// Depends on hfa_pkg and hashed_feature_accumulator_defines.svh.
`include "hashed_feature_accumulator_defines.svh"

module hfa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  cmd,
	input logic [31:0] entry_pos,
	input logic [63:0] type_id,
	input logic [63:0] param_id,
	input logic [63:0] value_bits,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  coef_index,
	input logic [63:0] coef_value,
	input logic [1:0]  status,
	input logic        last
);

	`HFA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(coef_value) && $stable(coef_index) && $stable(status) && $stable(last), "stalled item changed")

	`HFA_ASSERT_NOW(a_err_single, out_valid && status != hfa_pkg::ST_OK, last && coef_index == 3'd0 && coef_value == 64'd0, "error item not a lone zero item")

	`HFA_ASSERT_NOW(a_mid_ok, out_valid && !last, status == hfa_pkg::ST_OK, "readout item carries an error")

	`HFA_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready, "ready right after an accepted item")

endmodule

bind hashed_feature_accumulator hfa_checker u_hfa_checker (.*);

[verif/testbench.sv]
`timescale 1ns / 100ps
// Self-checking bench for hashed_feature_accumulator: directed table, a repeated-entry
// run and random items under four handshake idling mixes, checked by an in-bench model.
// Depends on hfa_pkg and the hashed_feature_accumulator RTL.
module testbench;
	import hfa_pkg::*;

	localparam int          CYCLE_LIMIT   = 4_000_000;
	localparam int          RANDOM_ITEMS  = 400;
	localparam int          BURST_ITEMS   = 40;
	localparam int          DRAIN_CYCLES  = 160;
	localparam int          MAX_GAP       = 40;
	localparam int          DIRECTED_ROWS = 23;
	localparam logic [63:0] ONES64        = 64'hffff_ffff_ffff_ffff;
	localparam logic [63:0] MINUS_ZERO    = 64'h8000_0000_0000_0000;
	localparam logic signed [63:0] UNIT_ONE  = 64'sh0010_0000_0000_0000;
	localparam logic signed [63:0] RAIL_UNIT = 64'sh000f_0000_0000_0000;
	localparam logic signed [63:0] SUM_MAX   = 64'sh7fff_ffff_ffff_ffff;
	localparam logic signed [63:0] SUM_MIN   = 64'sh8000_0000_0000_0000;
	localparam int SEND_IDLE [4] = '{0, 63, 0, 26};
	localparam int RECV_IDLE [4] = '{0, 0, 63, 26};

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] idx;
		logic [63:0] tid;
		logic [63:0] pid;
		logic [63:0] vbits;
		logic        typed;
		logic [1:0]  st;
	} genome_item_t;

	typedef struct packed {
		logic [2:0]  lane;
		logic [63:0] sum;
		logic [1:0]  st;
		logic        fin;
	} coef_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  cmd = CMD_CLEAR;
	logic [31:0] entry_pos = '0;
	logic [63:0] type_id = '0;
	logic [63:0] param_id = '0;
	logic [63:0] value_bits = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  coef_index;
	logic [63:0] coef_value;
	logic [1:0]  status;
	logic        last;

	hashed_feature_accumulator i_dut (.*);

	logic signed [63:0] model_sums [NUM_COEFFS] = '{default: '0};
	logic [63:0]        model_seed = '0;
	logic               model_open = 1'b0;
	coef_result_t       results_due [$];
	genome_item_t       directed_rows [DIRECTED_ROWS];

	int          send_pct = 0;
	int          recv_pct = 0;
	int          errors = 0;
	int          items_sent = 0;
	int          results_checked = 0;
	int unsigned cycle_count = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [63:0] splitmix(input logic [63:0] x);
		logic [63:0] v;
		v = x + GOLDEN;
		v = (v ^ (v >> 30)) * MIXK1;
		v = (v ^ (v >> 27)) * MIXK2;
		return v ^ (v >> 31);
	endfunction

	function automatic logic [63:0] seed_combine(input logic [63:0] s, input logic [63:0] v);
		return splitmix(s ^ (splitmix(v) + GOLDEN + (s << 6) + (s >> 2)));
	endfunction

	// signed unit in [-1, 1) with 52 fraction bits
	function automatic logic signed [63:0] lane_unit(input logic [63:0] seed, input int k);
		return $signed(seed_combine(seed, 64'(k)) >> 11) - UNIT_ONE;
	endfunction

	function automatic logic signed [63:0] sat_sum(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [63:0] s;
		s = a + b;
		if (!a[63] && !b[63] && s[63])
			return SUM_MAX;
		if (a[63] && b[63] && !s[63])
			return SUM_MIN;
		return s;
	endfunction

	task automatic add_lanes(input logic [63:0] seed);
		for (int k = 0; k < NUM_COEFFS; k++)
			model_sums[k] = sat_sum(model_sums[k], lane_unit(seed, k));
	endtask

	task automatic fold_item(input genome_item_t it);
		logic [63:0]  seed;
		logic [63:0]  vb;
		logic [1:0]   st;
		coef_result_t r;
		st = ST_OK;
		case (it.op)
		CMD_CLEAR: begin
			for (int k = 0; k < NUM_COEFFS; k++)
				model_sums[k] = '0;
		end
		CMD_ENTRY: begin
			model_seed = seed_combine({32'b0, it.idx}, it.tid);
			model_open = 1'b1;
			add_lanes(model_seed);
		end
		CMD_PARAM: begin
			if (!model_open) begin
				st = ST_NO_ENTRY;
			end else if (it.vbits[62:52] == 11'h7ff) begin
				st = ST_NONFINITE;
			end else begin
				vb = (it.vbits == MINUS_ZERO) ? 64'd0 : it.vbits;
				seed = seed_combine(seed_combine(model_seed, it.pid), vb);
				add_lanes(seed);
			end
		end
		default: ;
		endcase
		if (it.op == CMD_READ) begin
			for (int k = 0; k < NUM_COEFFS; k++) begin
				r.lane = k[2:0];
				r.sum  = it.typed ? 64'd0 : model_sums[k];
				r.st   = ST_OK;
				r.fin  = (k == NUM_COEFFS - 1);
				results_due.push_back(r);
			end
		end else begin
			r.lane = '0;
			r.sum  = '0;
			r.st   = it.typed ? it.st : st;
			r.fin  = 1'b1;
			results_due.push_back(r);
		end
	endtask

	task automatic send_item(input genome_item_t it);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < send_pct && gap < MAX_GAP)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		cmd         <= it.op;
		entry_pos   <= it.idx;
		type_id     <= it.tid;
		param_id    <= it.pid;
		value_bits  <= it.vbits;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		fold_item(it);
		items_sent++;
	endtask

	always @(posedge clk)
		out_ready <= ($urandom_range(0, 99) >= recv_pct);

	always @(posedge clk) begin
		coef_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (results_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, got index %0d value %h status %0d last %0b",
					$time, coef_index, coef_value, status, last);
			end else begin
				want = results_due.pop_front();
				results_checked++;
				if (coef_index !== want.lane) begin
					errors++;
					$display("%0t: coef_index expected %0d, got %0d", $time, want.lane, coef_index);
				end
				if (coef_value !== want.sum) begin
					errors++;
					$display("%0t: coef_value expected %h, got %h", $time, want.sum, coef_value);
				end
				if (status !== want.st) begin
					errors++;
					$display("%0t: status expected %0d, got %0d", $time, want.st, status);
				end
				if (last !== want.fin) begin
					errors++;
					$display("%0t: last expected %0b, got %0b", $time, want.fin, last);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d results still pending",
				$time, cycle_count, results_due.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		genome_item_t       it;
		genome_item_t       burst;
		logic [63:0]        seed;
		logic signed [63:0] u;
		bit                 hi;
		bit                 lo;
		int                 r;

		// fields: op, idx, tid, pid, vbits, typed, st
		directed_rows = '{
			'{CMD_READ,  32'hffff_ffff, ONES64, ONES64, ONES64, 1'b1, ST_OK},
			'{CMD_PARAM, 32'h0, 64'h0, 64'h0, 64'h3ff0_0000_0000_0000, 1'b1, ST_NO_ENTRY},
			'{CMD_PARAM, 32'h0, 64'h0, ONES64, 64'h7ff0_0000_0000_0000, 1'b1, ST_NO_ENTRY},
			'{CMD_CLEAR, 32'hffff_ffff, ONES64, ONES64, ONES64, 1'b1, ST_OK},
			'{CMD_PARAM, 32'h0, 64'h0, 64'h1234, 64'h0, 1'b1, ST_NO_ENTRY},
			'{CMD_ENTRY, 32'h0, 64'h0, ONES64, ONES64, 1'b0, ST_OK},
			'{CMD_PARAM, 32'h0, 64'h0, 64'h0, 64'h0, 1'b0, ST_OK},
			'{CMD_PARAM, 32'h0, 64'h0, 64'h0, MINUS_ZERO, 1'b0, ST_OK},
			'{CMD_PARAM, 32'h0, 64'h0, 64'h5, 64'h7ff0_0000_0000_0000, 1'b1, ST_NONFINITE},
			'{CMD_PARAM, 32'h0, 64'h0, 64'h5, 64'hfff8_0000_0000_0001, 1'b1, ST_NONFINITE},
			'{CMD_PARAM, 32'h0, 64'h0, ONES64, ONES64, 1'b1, ST_NONFINITE},
			'{CMD_PARAM, 32'h0, 64'h0, 64'h5, 64'h7fef_ffff_ffff_ffff, 1'b0, ST_OK},
			'{CMD_PARAM, 32'h0, 64'h0, 64'h5, 64'h0000_0000_0000_0001, 1'b0, ST_OK},
			'{CMD_READ,  32'hffff_ffff, ONES64, ONES64, ONES64, 1'b0, ST_OK},
			'{CMD_ENTRY, 32'hffff_ffff, ONES64, 64'h0, 64'h0, 1'b0, ST_OK},
			'{CMD_PARAM, 32'h0, 64'h0, ONES64, 64'hffef_ffff_ffff_ffff, 1'b0, ST_OK},
			'{CMD_ENTRY, 32'h8000_0000, MINUS_ZERO, 64'h0, 64'h0, 1'b0, ST_OK},
			'{CMD_PARAM, 32'h0, 64'h0, MINUS_ZERO, 64'h8000_0000_0000_0001, 1'b0, ST_OK},
			'{CMD_READ,  32'h0, 64'h0, 64'h0, 64'h0, 1'b0, ST_OK},
			'{CMD_CLEAR, 32'h0, 64'h0, 64'h0, 64'h0, 1'b1, ST_OK},
			'{CMD_READ,  32'h0, 64'h0, 64'h0, 64'h0, 1'b1, ST_OK},
			'{CMD_PARAM, 32'h0, 64'h0, 64'h7, 64'h3ff0_0000_0000_0000, 1'b0, ST_OK},
			'{CMD_READ,  32'h0, 64'h0, 64'h0, 64'h0, 1'b0, ST_OK}
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_item(directed_rows[i]);

		// entry with one lane near +1 and one near -1: repeating it grows sums of both signs
		burst = '0;
		burst.op = CMD_ENTRY;
		do begin
			burst.idx = $urandom;
			burst.tid = {$urandom, $urandom};
			seed = seed_combine({32'b0, burst.idx}, burst.tid);
			hi = 1'b0;
			lo = 1'b0;
			for (int k = 0; k < NUM_COEFFS; k++) begin
				u = lane_unit(seed, k);
				if (u >= RAIL_UNIT)
					hi = 1'b1;
				if (u <= -RAIL_UNIT)
					lo = 1'b1;
			end
		end while (!(hi && lo));
		it = '0;
		it.op = CMD_CLEAR;
		send_item(it);
		repeat (BURST_ITEMS)
			send_item(burst);
		it.op = CMD_READ;
		send_item(it);

		for (int p = 0; p < 4; p++) begin
			send_pct = SEND_IDLE[p];
			recv_pct = RECV_IDLE[p];
			repeat (RANDOM_ITEMS / 4) begin
				r = $urandom_range(0, 99);
				it.op = (r < 20) ? CMD_ENTRY : (r < 75) ? CMD_PARAM :
					(r < 93) ? CMD_READ : CMD_CLEAR;
				it.idx   = $urandom;
				it.tid   = {$urandom, $urandom};
				it.pid   = {$urandom, $urandom};
				it.vbits = {$urandom, $urandom};
				it.typed = 1'b0;
				it.st    = ST_OK;
				if ($urandom_range(0, 9) == 0)
					it.idx = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
				case ($urandom_range(0, 15))
				0: it.vbits = '0;
				1: it.vbits = MINUS_ZERO;
				2: it.vbits[62:52] = 11'h7ff;
				3: it.vbits[62:0] = {11'h7ff, 52'd0};
				4: it.vbits[62:52] = 11'h000;
				default: begin
					if (it.vbits[62:52] == 11'h7ff)
						it.vbits[52] = 1'b0;
				end
				endcase
				send_item(it);
			end
		end
		in_valid <= 1'b0;

		while (results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d items sent (%0d-item repeated-entry run included), %0d results checked",
			items_sent, BURST_ITEMS, results_checked);
		$display("idling mixes: none, sender 63%%, receiver 63%%, both 26%%; %0d errors", errors);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
